[src/nttq_pkg.sv]
// ----------------------------------------------------------------------------
// nttq_pkg: shared types and constants for the mod-q NTT block
// Modulus, scale factor, item kinds, controller commands and twiddle ROM.
// ----------------------------------------------------------------------------
package nttq_pkg;

  localparam int unsigned PolyLength = 256;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned CoefW      = 23;
  localparam int unsigned ValueW     = 24;

  localparam logic [CoefW-1:0] ModQ      = 23'd8380417;
  localparam logic [CoefW-1:0] LengthInv = 23'd8347681;
  localparam longint unsigned  RootOfUnity = 64'd1753;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_INVERSE = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // write-back data source
  typedef enum logic [2:0] {
    WR_INPUT,
    WR_USUM,
    WR_UDIFF,
    WR_RAWSUM,
    WR_PROD
  } wr_sel_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr_a;
    logic [AddrW-1:0] rd_addr_b;
    logic [AddrW-1:0] tw_idx;
    logic             inverse;
    logic             scale;
    logic             pre_en;
    logic             mul_en;
    logic             f1_en;
    logic             f2_en;
    logic             f3_en;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    wr_sel_e          wr_sel;
    logic             out_load_read;
    logic             out_load_done;
  } ctrl_t;

  typedef logic [CoefW-1:0] tw_rom_t [PolyLength];

  // entry k: 1753^bitrev8(k) mod q, built at elaboration
  function automatic tw_rom_t build_twiddles();
    tw_rom_t         rom;
    longint unsigned r;
    longint unsigned b;
    logic [7:0]      kk;
    logic [7:0]      e;
    for (int k = 0; k < PolyLength; k++) begin
      kk = k[7:0];
      for (int i = 0; i < 8; i++) e[i] = kk[7-i];
      r = 64'd1;
      b = RootOfUnity;
      for (int i = 0; i < 8; i++) begin
        if (e[i]) r = (r * b) % 64'd8380417;
        b = (b * b) % 64'd8380417;
      end
      rom[k] = r[CoefW-1:0];
    end
    return rom;
  endfunction

endpackage

[src/nttq_in_if.sv]
// ----------------------------------------------------------------------------
// nttq_in_if: input word channel
// Valid/ready handshake carrying kind, index and signed value.
// ----------------------------------------------------------------------------
interface nttq_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [nttq_pkg::AddrW-1:0]   index;
  logic signed [nttq_pkg::ValueW-1:0] value;

  modport source  (output valid, kind, index, value, input ready);
  modport sink    (input valid, kind, index, value, output ready);
  modport monitor (input valid, ready, kind, index, value);
endinterface

[src/nttq_out_if.sv]
// ----------------------------------------------------------------------------
// nttq_out_if: result word channel
// Valid/ready handshake carrying coefficient and done flag.
// ----------------------------------------------------------------------------
interface nttq_out_if;
  logic                       valid;
  logic                       ready;
  logic [nttq_pkg::CoefW-1:0] coefficient;
  logic                       is_done;

  modport source  (output valid, coefficient, is_done, input ready);
  modport sink    (input valid, coefficient, is_done, output ready);
  modport monitor (input valid, ready, coefficient, is_done);
endinterface

[src/negacyclic_ntt_mod_q.sv]
// ----------------------------------------------------------------------------
// negacyclic_ntt_mod_q: 256-point negacyclic NTT engine modulo q = 8380417
// Holds one polynomial; write, read, forward and inverse transform items.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per item: kind, index and a signed 24-bit value.
//   Write words store value reduced into 0..q-1 at index; no result word.
//   Read words return the stored coefficient with is_done low.
//   Forward/inverse run words transform the whole polynomial in place and
//   return one word with coefficient zero and is_done high.
// Timing:
//   A write is stored at the accepting edge. A read result passes the read
//   register and then the output register before out_o.valid rises.
//   Each butterfly walks a sequence through the single multiplier pipeline
//   (read, operand prep, multiply, three reduction folds, two write-backs),
//   and an inverse run adds a scaling pass by 256^-1 after its butterflies.
//   One item is in work at a time; in_i.ready is low while a run or read is
//   in progress and while a result word waits on out_o.
// Reset clears the sequencer and the result valid; the coefficient memory
//   is not cleared, so entries must be written before they are read.
// A stalled receiver holds the result word and blocks new items.
// ----------------------------------------------------------------------------
module negacyclic_ntt_mod_q (
  input  logic       clk_i,
  input  logic       rst_ni,
  nttq_in_if.sink    in_i,
  nttq_out_if.source out_o
);

  nttq_pkg::ctrl_t ctrl;

  nttq_controller u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_kind_i     (in_i.kind),
    .in_index_i    (in_i.index),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_is_done_o (out_o.is_done),
    .ctrl_o        (ctrl)
  );

  nttq_datapath u_dp (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .value_i       (in_i.value),
    .coefficient_o (out_o.coefficient)
  );

endmodule

[src/nttq_datapath.sv]
// ----------------------------------------------------------------------------
// nttq_datapath: coefficient memory and butterfly arithmetic
// 256x23 memory, twiddle ROM, pipelined multiply with folding mod-q reduction.
// ----------------------------------------------------------------------------
module nttq_datapath (
  input  logic                               clk_i,
  input  nttq_pkg::ctrl_t                    ctrl_i,
  input  logic signed [nttq_pkg::ValueW-1:0] value_i,
  output logic [nttq_pkg::CoefW-1:0]         coefficient_o
);

  localparam nttq_pkg::tw_rom_t TwRom = nttq_pkg::build_twiddles();
  localparam logic [25:0] Q1 = {3'd0, nttq_pkg::ModQ};
  localparam logic [25:0] Q2 = Q1 + Q1;
  localparam logic [25:0] Q3 = Q2 + Q1;

  logic [nttq_pkg::CoefW-1:0] mem_q [nttq_pkg::PolyLength];

  logic [22:0] rda_q, rdb_q, zeta_q;
  logic [22:0] u_q, m_q, sum_q, t_q;
  logic [45:0] prod_q;
  logic [36:0] f1_q;
  logic [27:0] f2_q;
  logic [22:0] wr_data;
  logic [22:0] coef_q;

  function automatic logic [22:0] add_mod(input logic [22:0] a, input logic [22:0] b);
    logic [23:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, nttq_pkg::ModQ}) ? 23'(s - {1'b0, nttq_pkg::ModQ}) : s[22:0];
  endfunction

  function automatic logic [22:0] sub_mod(input logic [22:0] a, input logic [22:0] b);
    return (a >= b) ? 23'(a - b) : 23'(a + nttq_pkg::ModQ - b);
  endfunction

  // input reduction: sign-extended value plus 2q, then subtract up to 3q
  logic [25:0] in_s;
  logic [25:0] in_r;
  always_comb begin
    in_s = 26'($signed({{2{value_i[23]}}, value_i}) + $signed(Q2));
    if (in_s >= Q3)      in_r = in_s - Q3;
    else if (in_s >= Q2) in_r = in_s - Q2;
    else if (in_s >= Q1) in_r = in_s - Q1;
    else                 in_r = in_s;
  end

  // folds use 2^23 = 2^13 - 1 mod q
  logic [36:0] f1_d;
  logic [27:0] f2_d;
  logic [23:0] f3_s;
  always_comb begin
    f1_d = {14'd0, prod_q[22:0]} + {1'b0, prod_q[45:23], 13'd0} - {14'd0, prod_q[45:23]};
    f2_d = {5'd0, f1_q[22:0]} + {1'b0, f1_q[36:23], 13'd0} - {14'd0, f1_q[36:23]};
    f3_s = {1'b0, f2_q[22:0]} + {1'b0, 5'd0, f2_q[27:23], 13'd0} - {19'd0, f2_q[27:23]};
  end

  always_comb begin
    case (ctrl_i.wr_sel)
      nttq_pkg::WR_INPUT:  wr_data = in_r[22:0];
      nttq_pkg::WR_USUM:   wr_data = add_mod(u_q, t_q);
      nttq_pkg::WR_UDIFF:  wr_data = sub_mod(u_q, t_q);
      nttq_pkg::WR_RAWSUM: wr_data = sum_q;
      nttq_pkg::WR_PROD:   wr_data = t_q;
      default:             wr_data = t_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) mem_q[ctrl_i.wr_addr] <= wr_data;
    if (ctrl_i.rd_en) begin
      rda_q <= mem_q[ctrl_i.rd_addr_a];
      rdb_q <= mem_q[ctrl_i.rd_addr_b];
      if (ctrl_i.scale)        zeta_q <= nttq_pkg::LengthInv;
      else if (ctrl_i.inverse) zeta_q <= nttq_pkg::ModQ - TwRom[ctrl_i.tw_idx];
      else                     zeta_q <= TwRom[ctrl_i.tw_idx];
    end
    if (ctrl_i.pre_en) begin
      u_q   <= rda_q;
      sum_q <= add_mod(rda_q, rdb_q);
      if (ctrl_i.scale)        m_q <= rda_q;
      else if (ctrl_i.inverse) m_q <= sub_mod(rda_q, rdb_q);
      else                     m_q <= rdb_q;
    end
    if (ctrl_i.mul_en) prod_q <= {23'd0, m_q} * {23'd0, zeta_q};
    if (ctrl_i.f1_en)  f1_q   <= f1_d;
    if (ctrl_i.f2_en)  f2_q   <= f2_d;
    if (ctrl_i.f3_en) begin
      t_q <= (f3_s >= {1'b0, nttq_pkg::ModQ}) ? 23'(f3_s - {1'b0, nttq_pkg::ModQ})
                                             : f3_s[22:0];
    end
    if (ctrl_i.out_load_read)      coef_q <= rda_q;
    else if (ctrl_i.out_load_done) coef_q <= '0;
  end

  assign coefficient_o = coef_q;

endmodule

[src/nttq_controller.sv]
// ----------------------------------------------------------------------------
// nttq_controller: item sequencer
// Decodes items, walks butterfly stages and the scaling pass, owns handshake.
// ----------------------------------------------------------------------------
module nttq_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  in_kind_i,
  input  logic [nttq_pkg::AddrW-1:0]  in_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_is_done_o,
  output nttq_pkg::ctrl_t             ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ_WAIT, ST_RD, ST_PRE, ST_MUL, ST_F1, ST_F2, ST_F3,
    ST_WA, ST_WB, ST_FINISH
  } state_e;

  state_e     state_q;
  logic       inverse_q, scale_q, out_valid_q, is_done_q;
  logic [2:0] stage_q;
  logic [7:0] cnt_q;

  logic       accept;
  logic [2:0] lvl;
  logic [7:0] grp, j_a, j_b, mask, tw_k;
  logic [8:0] tw_inv;

  assign in_ready_o    = (state_q == ST_IDLE) && !out_valid_q;
  assign accept        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign out_is_done_o = is_done_q;

  // butterfly addressing: half-span 2^lvl
  always_comb begin
    lvl    = inverse_q ? stage_q : 3'(3'd7 - stage_q);
    grp    = cnt_q >> lvl;
    mask   = (8'd1 << lvl) - 8'd1;
    j_a    = 8'((grp << lvl) << 1) | (cnt_q & mask);
    j_b    = j_a | (8'd1 << lvl);
    tw_inv = (9'd256 >> lvl) - 9'd1 - {1'b0, grp};
    tw_k   = inverse_q ? tw_inv[7:0] : 8'((8'd128 >> lvl) + grp);
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.wr_sel  = nttq_pkg::WR_INPUT;
    ctrl_o.inverse = inverse_q;
    ctrl_o.scale   = scale_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.rd_addr_a = in_index_i;
        ctrl_o.wr_addr   = in_index_i;
        if (accept && in_kind_i == nttq_pkg::KIND_WRITE) ctrl_o.wr_en = 1'b1;
        if (accept && in_kind_i == nttq_pkg::KIND_READ)  ctrl_o.rd_en = 1'b1;
      end
      ST_READ_WAIT: ctrl_o.out_load_read = 1'b1;
      ST_RD: begin
        ctrl_o.rd_en     = 1'b1;
        ctrl_o.rd_addr_a = scale_q ? cnt_q : j_a;
        ctrl_o.rd_addr_b = j_b;
        ctrl_o.tw_idx    = tw_k;
      end
      ST_PRE: ctrl_o.pre_en = 1'b1;
      ST_MUL: ctrl_o.mul_en = 1'b1;
      ST_F1:  ctrl_o.f1_en  = 1'b1;
      ST_F2:  ctrl_o.f2_en  = 1'b1;
      ST_F3:  ctrl_o.f3_en  = 1'b1;
      ST_WA: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_addr = scale_q ? cnt_q : j_a;
        if (scale_q)        ctrl_o.wr_sel = nttq_pkg::WR_PROD;
        else if (inverse_q) ctrl_o.wr_sel = nttq_pkg::WR_RAWSUM;
        else                ctrl_o.wr_sel = nttq_pkg::WR_USUM;
      end
      ST_WB: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_addr = j_b;
        ctrl_o.wr_sel  = inverse_q ? nttq_pkg::WR_PROD : nttq_pkg::WR_UDIFF;
      end
      ST_FINISH: ctrl_o.out_load_done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inverse_q   <= 1'b0;
      scale_q     <= 1'b0;
      stage_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      is_done_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_kind_i)
              nttq_pkg::KIND_READ: state_q <= ST_READ_WAIT;
              nttq_pkg::KIND_FORWARD, nttq_pkg::KIND_INVERSE: begin
                inverse_q <= (in_kind_i == nttq_pkg::KIND_INVERSE);
                scale_q   <= 1'b0;
                stage_q   <= '0;
                cnt_q     <= '0;
                state_q   <= ST_RD;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_READ_WAIT: begin
          out_valid_q <= 1'b1;
          is_done_q   <= 1'b0;
          state_q     <= ST_IDLE;
        end
        ST_RD:  state_q <= ST_PRE;
        ST_PRE: state_q <= ST_MUL;
        ST_MUL: state_q <= ST_F1;
        ST_F1:  state_q <= ST_F2;
        ST_F2:  state_q <= ST_F3;
        ST_F3:  state_q <= ST_WA;
        ST_WA: begin
          if (!scale_q) begin
            state_q <= ST_WB;
          end else if (cnt_q == 8'd255) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q   <= cnt_q + 8'd1;
            state_q <= ST_RD;
          end
        end
        ST_WB: begin
          if (cnt_q == 8'd127) begin
            cnt_q <= '0;
            if (stage_q == 3'd7) begin
              if (inverse_q) begin
                scale_q <= 1'b1;
                state_q <= ST_RD;
              end else begin
                state_q <= ST_FINISH;
              end
            end else begin
              stage_q <= stage_q + 3'd1;
              state_q <= ST_RD;
            end
          end else begin
            cnt_q   <= cnt_q + 8'd1;
            state_q <= ST_RD;
          end
        end
        ST_FINISH: begin
          out_valid_q <= 1'b1;
          is_done_q   <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/negacyclic_ntt_mod_q_checker.sv]
// ----------------------------------------------------------------------------
// negacyclic_ntt_mod_q_checker: result predictor and scoreboard
// Watches both word channels, keeps its own copy of the polynomial and the
// transforms, and compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module negacyclic_ntt_mod_q_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nttq_in_if.monitor  in_mon,
  nttq_out_if.monitor out_mon,
  output int unsigned mismatches_o,
  output int unsigned waiting_o
);

  localparam longint unsigned Q = 64'd8380417;

  typedef struct {
    logic [nttq_pkg::CoefW-1:0] coefficient;
    logic                       is_done;
  } result_t;

  longint unsigned poly[nttq_pkg::PolyLength];
  longint unsigned zeta[nttq_pkg::PolyLength];
  result_t         expected_words[$];

  function automatic longint unsigned root_power(int k);
    longint unsigned r;
    longint unsigned b;
    int              e;
    e = 0;
    for (int i = 0; i < 8; i++) e = (e << 1) | ((k >> i) & 1);
    r = 1;
    b = 1753;
    while (e != 0) begin
      if (e & 1) r = (r * b) % Q;
      b = (b * b) % Q;
      e = e >> 1;
    end
    return r;
  endfunction

  initial begin
    for (int k = 0; k < nttq_pkg::PolyLength; k++) zeta[k] = root_power(k);
  end

  task automatic transform_forward();
    int              k;
    longint unsigned t;
    longint unsigned u;
    k = 0;
    for (int len = nttq_pkg::PolyLength / 2; len > 0; len = len / 2) begin
      for (int s = 0; s < nttq_pkg::PolyLength; s += 2 * len) begin
        k++;
        for (int j = s; j < s + len; j++) begin
          t = (zeta[k] * poly[j + len]) % Q;
          u = poly[j];
          poly[j + len] = (u + Q - t) % Q;
          poly[j]       = (u + t) % Q;
        end
      end
    end
  endtask

  task automatic transform_inverse();
    int              k;
    longint unsigned z;
    longint unsigned u;
    longint unsigned v;
    k = nttq_pkg::PolyLength;
    for (int len = 1; len < nttq_pkg::PolyLength; len = len * 2) begin
      for (int s = 0; s < nttq_pkg::PolyLength; s += 2 * len) begin
        k--;
        z = Q - zeta[k];
        for (int j = s; j < s + len; j++) begin
          u = poly[j];
          v = poly[j + len];
          poly[j]       = (u + v) % Q;
          poly[j + len] = (z * ((u + Q - v) % Q)) % Q;
        end
      end
    end
    for (int j = 0; j < nttq_pkg::PolyLength; j++) poly[j] = (poly[j] * 64'd8347681) % Q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t         r;
    result_t         e;
    longint          sv;
    if (!rst_ni) begin
      mismatches_o <= 0;
      waiting_o    <= 0;
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        case (nttq_pkg::kind_e'(in_mon.kind))
          nttq_pkg::KIND_WRITE: begin
            sv = longint'(in_mon.value) + 2 * longint'(Q);
            poly[in_mon.index] = longint'(sv) % Q;
          end
          nttq_pkg::KIND_READ: begin
            r.coefficient = poly[in_mon.index][nttq_pkg::CoefW-1:0];
            r.is_done = 1'b0;
            expected_words = {expected_words, r};
          end
          default: begin
            if (nttq_pkg::kind_e'(in_mon.kind) == nttq_pkg::KIND_FORWARD) transform_forward();
            else transform_inverse();
            r.coefficient = '0;
            r.is_done = 1'b1;
            expected_words = {expected_words, r};
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatches_o < 10)
            $display("unexpected result word: coef=%0d done=%0b",
                     out_mon.coefficient, out_mon.is_done);
          mismatches_o <= mismatches_o + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.coefficient !== out_mon.coefficient || e.is_done !== out_mon.is_done) begin
            if (mismatches_o < 10)
              $display("result word: expected coef=%0d done=%0b, got coef=%0d done=%0b",
                       e.coefficient, e.is_done, out_mon.coefficient, out_mon.is_done);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      waiting_o <= $unsigned(expected_words.size());
    end
  end

endmodule

[tb/negacyclic_ntt_mod_q_tb.sv]
// ----------------------------------------------------------------------------
// negacyclic_ntt_mod_q_tb: testbench top for the mod-q NTT engine
// Fills the polynomial, runs directed extremes and transforms, then random
// writes, reads and runs with random idling on both sides; verdict at end.
// ----------------------------------------------------------------------------
module negacyclic_ntt_mod_q_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;       // no idling on either side while set
  int unsigned mismatches;
  int unsigned waiting;

  nttq_in_if  in_ch ();
  nttq_out_if out_ch ();

  negacyclic_ntt_mod_q dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  negacyclic_ntt_mod_q_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch.monitor),
    .out_mon     (out_ch.monitor),
    .mismatches_o(mismatches),
    .waiting_o   (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure unless calm is set; ready drops with a chance of 14 in 100.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Hand one word to the block; returns after the accepting edge.
  task automatic send_word(nttq_pkg::kind_e k, logic [nttq_pkg::AddrW-1:0] idx,
                           logic [nttq_pkg::ValueW-1:0] v);
    logic took;
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.index <= idx;
    in_ch.value <= v;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;   // stable mid-cycle, decides the next edge
      @(posedge clk_i);
    end while (!took);
  endtask

  function automatic logic [nttq_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 24'(-8380416);
      1:       return 24'd8380416;
      2:       return 24'h800000;
      3:       return 24'h7FFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    int   r;
    nttq_pkg::kind_e k;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = nttq_pkg::KIND_WRITE;
    in_ch.index  = '0;
    in_ch.value  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry written before any read or run
    for (int i = 0; i < nttq_pkg::PolyLength; i++)
      send_word(nttq_pkg::KIND_WRITE, 8'(i), pick_value());

    // directed: value extremes, both ends of the index, both transforms
    send_word(nttq_pkg::KIND_WRITE, 8'd0,   24'(-8380416));
    send_word(nttq_pkg::KIND_WRITE, 8'd255, 24'd8380416);
    send_word(nttq_pkg::KIND_WRITE, 8'd1,   24'h800000);   // below -q, wraps twice
    send_word(nttq_pkg::KIND_WRITE, 8'd254, 24'h7FFFFF);   // above q
    send_word(nttq_pkg::KIND_WRITE, 8'd2,   24'hFFFFFF);
    send_word(nttq_pkg::KIND_WRITE, 8'd3,   24'd0);
    for (int i = 0; i < 4; i++) send_word(nttq_pkg::KIND_READ, 8'(i), 24'($urandom()));
    send_word(nttq_pkg::KIND_READ, 8'd254, 24'd0);
    send_word(nttq_pkg::KIND_READ, 8'd255, 24'hFFFFFF);
    send_word(nttq_pkg::KIND_FORWARD, 8'hFF, 24'hFFFFFF);  // index and value unused
    send_word(nttq_pkg::KIND_READ, 8'd0, 24'd0);
    send_word(nttq_pkg::KIND_READ, 8'd255, 24'd0);
    send_word(nttq_pkg::KIND_INVERSE, 8'h00, 24'h000000);
    send_word(nttq_pkg::KIND_READ, 8'd0, 24'd0);
    send_word(nttq_pkg::KIND_READ, 8'd255, 24'd0);

    for (int n = 0; n < 230; n++) begin
      calm = (n >= 60 && n < 160);
      if (n == 180) begin
        @(negedge clk_i);
        wait (waiting == 0);
      end
      r = $urandom_range(99);
      k = (r < 47) ? nttq_pkg::KIND_WRITE : (r < 94) ? nttq_pkg::KIND_READ :
          (r < 97) ? nttq_pkg::KIND_FORWARD : nttq_pkg::KIND_INVERSE;
      send_word(k, 8'($urandom()),
                (k == nttq_pkg::KIND_WRITE) ? pick_value() : 24'($urandom()));
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(negedge clk_i);
    wait (waiting == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("negacyclic_ntt_mod_q: match");
    end else begin
      $display("negacyclic_ntt_mod_q: mismatch");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("negacyclic_ntt_mod_q: mismatch");
    $finish;
  end

endmodule

[negacyclic_ntt_mod_q.f]
src/nttq_pkg.sv
src/nttq_in_if.sv
src/nttq_out_if.sv
src/nttq_datapath.sv
src/nttq_controller.sv
src/negacyclic_ntt_mod_q.sv
tb/negacyclic_ntt_mod_q_checker.sv
tb/negacyclic_ntt_mod_q_tb.sv
